>>> hdl/pinhole_camera_projection_core_defines.svh
// ----------------------------------------------------------------------------
// pinhole camera projection core - assertion macros
// Shared assertion forms for the checker; clock and reset are taken from the
// enclosing scope.
// ----------------------------------------------------------------------------
`ifndef PINHOLE_CAMERA_PROJECTION_CORE_DEFINES_SVH
`define PINHOLE_CAMERA_PROJECTION_CORE_DEFINES_SVH

// same-cycle implication
`define PCP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pcp assertion failed");

// next-cycle implication
`define PCP_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pcp assertion failed");

`endif

>>> hdl/pcp_pkg.sv
// ----------------------------------------------------------------------------
// pcp_pkg
// Types, codes and helpers shared by the pinhole camera projection core.
// ----------------------------------------------------------------------------
package pcp_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int ROT_FRAC      = 16;
   localparam int QUOT_BITS     = 35;
   localparam int DIV_LAT       = QUOT_BITS + 2;

   localparam logic [2:0] MODE_W2P = 3'd0;
   localparam logic [2:0] MODE_P2W = 3'd1;
   localparam logic [2:0] MODE_C2P = 3'd2;
   localparam logic [2:0] MODE_P2C = 3'd3;
   localparam logic [2:0] MODE_W2C = 3'd4;
   localparam logic [2:0] MODE_C2W = 3'd5;

   localparam logic [2:0] CSR_FOCAL = 3'd0;
   localparam logic [2:0] CSR_PRINC = 3'd1;
   localparam logic [2:0] CSR_ROW0  = 3'd2;
   localparam logic [2:0] CSR_ROW1  = 3'd3;
   localparam logic [2:0] CSR_ROW2  = 3'd4;
   localparam logic [2:0] CSR_TX    = 3'd5;
   localparam logic [2:0] CSR_TY    = 3'd6;
   localparam logic [2:0] CSR_TZ    = 3'd7;

   localparam logic [53:0] ROW0_RST = 54'(1) << ROT_FRAC;
   localparam logic [53:0] ROW1_RST = 54'(1) << (18 + ROT_FRAC);
   localparam logic [53:0] ROW2_RST = 54'(1) << (36 + ROT_FRAC);

   localparam logic signed [39:0] S32_MAX = 40'sd2147483647;
   localparam logic signed [39:0] S32_MIN = -40'sd2147483648;

   typedef logic [53:0] pcp_row_type;
   typedef logic [2:0][17:0] pcp_mrow_type;
   typedef pcp_mrow_type [2:0] pcp_mat_type;
   typedef logic [2:0][31:0] pcp_vec_type;

   typedef struct packed {
      logic               valid;
      logic [2:0]         mode;
      logic               bad;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } pcp_point_type;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX) begin
         r = 32'sh7fffffff;
      end else if (v < S32_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> hdl/pcp_rot.sv
// ----------------------------------------------------------------------------
// pcp_rot
// Three-stage rotation unit: optional pre-subtract of t, 3x3 multiply,
// rounded sum with optional add of t and saturation.
// ----------------------------------------------------------------------------
module pcp_rot (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic [7:0]            act_modes,
   input  logic                  pre_sub,
   input  pcp_pkg::pcp_mat_type  mat,
   input  pcp_pkg::pcp_vec_type  trans,
   input  pcp_pkg::pcp_point_type pt_in,
   output pcp_pkg::pcp_point_type pt_out
);

   logic signed [32:0] v_in [3];
   logic signed [32:0] v_ff [3];
   logic signed [31:0] c_in [3];
   logic               act1_ff, act2_ff;
   pcp_pkg::pcp_point_type rec1_ff, rec2_ff, rec3_ff, rec3_in;

   logic signed [50:0] prod_in [3][3];
   logic signed [50:0] prod_ff [3][3];

   logic signed [52:0] acc [3];
   logic signed [52:0] shr [3];
   logic signed [39:0] res [3];
   logic signed [31:0] sat_v [3];

   assign c_in[0] = pt_in.x;
   assign c_in[1] = pt_in.y;
   assign c_in[2] = pt_in.z;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (pre_sub) begin
            v_in[k] = 33'(c_in[k]) - 33'($signed(trans[k]));
         end else begin
            v_in[k] = 33'(c_in[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec1_ff.valid <= 1'b0;
      end else if (adv) begin
         rec1_ff <= pt_in;
         act1_ff <= act_modes[pt_in.mode];
         for (int k = 0; k < 3; k++) v_ff[k] <= v_in[k];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = 51'($signed(mat[i][j])) * 51'(v_ff[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec2_ff.valid <= 1'b0;
      end else if (adv) begin
         rec2_ff <= rec1_ff;
         act2_ff <= act1_ff;
         prod_ff <= prod_in;
      end
   end

   // round to nearest with ties up, then drop the rotation fraction
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i] = 53'(prod_ff[i][0]) + 53'(prod_ff[i][1]) + 53'(prod_ff[i][2]);
         shr[i] = (acc[i] + 53'sd32768) >>> pcp_pkg::ROT_FRAC;
         res[i] = $signed(shr[i][39:0])
                  + (pre_sub ? 40'sd0 : 40'($signed(trans[i])));
         sat_v[i] = pcp_pkg::sat32(res[i]);
      end
   end

   always_comb begin
      rec3_in = rec2_ff;
      if (act2_ff) begin
         rec3_in.x = sat_v[0];
         rec3_in.y = sat_v[1];
         rec3_in.z = sat_v[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec3_ff.valid <= 1'b0;
      end else if (adv) begin
         rec3_ff <= rec3_in;
      end
   end

   assign pt_out = rec3_ff;

endmodule

>>> hdl/pcp_div.sv
// ----------------------------------------------------------------------------
// pcp_div
// Pipelined restoring divider, one quotient bit per stage, with round to
// nearest on the magnitude and saturation of large quotients.
// ----------------------------------------------------------------------------
module pcp_div (
   input  logic        clock,
   input  logic        adv,
   input  logic [63:0] num,
   input  logic [31:0] den,
   output logic [pcp_pkg::QUOT_BITS:0] quo
);

   localparam int QB = pcp_pkg::QUOT_BITS;

   logic [31:0]   rem_ff  [QB+1];
   logic [QB-1:0] low_ff  [QB+1];
   logic [31:0]   den_ff  [QB+1];
   logic [QB-1:0] q_ff    [QB+1];
   logic          ovf_ff  [QB+1];
   logic          zero_ff [QB+1];
   logic [QB:0]   quo_ff;
   logic          ovf_in;
   logic          rnd;

   // quotient too large for the stage count, or a nonzero numerator over zero
   assign ovf_in = (den == 32'd0) ? (num != 64'd0) : (32'(num[63:QB]) >= den);

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= 32'(num[63:QB]);
         low_ff[0]  <= num[QB-1:0];
         den_ff[0]  <= den;
         q_ff[0]    <= '0;
         ovf_ff[0]  <= ovf_in;
         zero_ff[0] <= (den == 32'd0) && (num == 64'd0);
      end
   end

   genvar s;
   generate
      for (s = 1; s <= QB; s++) begin : g_step
         logic [32:0] sh;
         logic        ge;
         assign sh = {rem_ff[s-1], low_ff[s-1][QB-1]};
         assign ge = sh >= {1'b0, den_ff[s-1]};
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[s]  <= ge ? 32'(sh - {1'b0, den_ff[s-1]}) : sh[31:0];
               low_ff[s]  <= low_ff[s-1] << 1;
               den_ff[s]  <= den_ff[s-1];
               q_ff[s]    <= {q_ff[s-1][QB-2:0], ge};
               ovf_ff[s]  <= ovf_ff[s-1];
               zero_ff[s] <= zero_ff[s-1];
            end
         end
      end
   endgenerate

   assign rnd = {rem_ff[QB], 1'b0} >= {1'b0, den_ff[QB]};

   always_ff @(posedge clock) begin
      if (adv) begin
         if (ovf_ff[QB]) begin
            quo_ff <= (QB+1)'(1) << QB;
         end else if (zero_ff[QB]) begin
            quo_ff <= '0;
         end else begin
            quo_ff <= {1'b0, q_ff[QB]} + (QB+1)'(rnd);
         end
      end
   end

   assign quo = quo_ff;

endmodule

>>> hdl/pcp_proj.sv
// ----------------------------------------------------------------------------
// pcp_proj
// Projection and back-projection unit: operand setup, multiply, two divider
// lanes for the pixel axes, then offset, sign and saturation.
// ----------------------------------------------------------------------------
module pcp_proj (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic [31:0]            fx,
   input  logic [31:0]            fy,
   input  logic [31:0]            cx,
   input  logic [31:0]            cy,
   input  pcp_pkg::pcp_point_type pt_in,
   output pcp_pkg::pcp_point_type pt_out
);

   localparam int QB  = pcp_pkg::QUOT_BITS;
   localparam int LAT = pcp_pkg::DIV_LAT;

   logic signed [31:0] a_v [2];
   logic [31:0]        f_v [2];
   logic [31:0]        c_v [2];
   logic               is_proj, is_back;

   logic signed [33:0] dd    [2];
   logic [32:0]        op1_in [2];
   logic [31:0]        op2_in [2];
   logic               neg_in [2];
   logic [31:0]        den_in [2];
   logic [31:0]        zmag;

   logic [32:0] op1_ff [2];
   logic [31:0] op2_ff [2];
   logic        neg1_ff [2];
   logic [31:0] den1_ff [2];
   pcp_pkg::pcp_point_type rec1_in, rec1_ff, rec2_ff;

   logic [63:0] num2_ff [2];
   logic [31:0] den2_ff [2];
   logic        neg2_ff [2];

   logic [QB:0] quo [2];
   logic        neg_dly_ff [LAT][2];
   pcp_pkg::pcp_point_type rec_dly_ff [LAT];
   pcp_pkg::pcp_point_type last, res_in, res_ff;
   logic signed [39:0] sq  [2];
   logic signed [31:0] val [2];
   logic               last_proj, last_back;

   assign a_v[0] = pt_in.x;
   assign a_v[1] = pt_in.y;
   assign f_v[0] = fx;
   assign f_v[1] = fy;
   assign c_v[0] = cx;
   assign c_v[1] = cy;

   assign is_proj = (pt_in.mode == pcp_pkg::MODE_W2P) || (pt_in.mode == pcp_pkg::MODE_C2P);
   assign is_back = (pt_in.mode == pcp_pkg::MODE_P2W) || (pt_in.mode == pcp_pkg::MODE_P2C);
   assign zmag    = pt_in.z[31] ? 32'(-pt_in.z) : pt_in.z;

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         dd[k]     = 34'(a_v[k]) - $signed({2'b00, c_v[k]});
         op1_in[k] = '0;
         op2_in[k] = '0;
         neg_in[k] = 1'b0;
         den_in[k] = '0;
         if (is_proj) begin
            op1_in[k] = {1'b0, f_v[k]};
            op2_in[k] = a_v[k][31] ? 32'(-a_v[k]) : a_v[k];
            neg_in[k] = a_v[k][31];
            den_in[k] = pt_in.z;
         end else if (is_back) begin
            op1_in[k] = dd[k][33] ? 33'(-dd[k]) : dd[k][32:0];
            op2_in[k] = zmag;
            neg_in[k] = dd[k][33] ^ pt_in.z[31];
            den_in[k] = f_v[k];
         end
      end
   end

   always_comb begin
      rec1_in     = pt_in;
      rec1_in.bad = is_proj && (pt_in.z <= 32'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec1_ff.valid <= 1'b0;
      end else if (adv) begin
         rec1_ff     <= rec1_in;
         op1_ff      <= op1_in;
         op2_ff      <= op2_in;
         neg1_ff     <= neg_in;
         den1_ff     <= den_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec2_ff.valid <= 1'b0;
      end else if (adv) begin
         rec2_ff <= rec1_ff;
         for (int k = 0; k < 2; k++) begin
            num2_ff[k] <= 64'(65'(op1_ff[k]) * 65'(op2_ff[k]));
         end
         den2_ff <= den1_ff;
         neg2_ff <= neg1_ff;
      end
   end

   pcp_div u_div_x (
      .clock (clock),
      .adv   (adv),
      .num   (num2_ff[0]),
      .den   (den2_ff[0]),
      .quo   (quo[0])
   );

   pcp_div u_div_y (
      .clock (clock),
      .adv   (adv),
      .num   (num2_ff[1]),
      .den   (den2_ff[1]),
      .quo   (quo[1])
   );

   // request record and signs ride alongside the divider lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LAT; s++) rec_dly_ff[s].valid <= 1'b0;
      end else if (adv) begin
         rec_dly_ff[0] <= rec2_ff;
         neg_dly_ff[0] <= neg2_ff;
         for (int s = 1; s < LAT; s++) begin
            rec_dly_ff[s] <= rec_dly_ff[s-1];
            neg_dly_ff[s] <= neg_dly_ff[s-1];
         end
      end
   end

   assign last      = rec_dly_ff[LAT-1];
   assign last_proj = (last.mode == pcp_pkg::MODE_W2P) || (last.mode == pcp_pkg::MODE_C2P);
   assign last_back = (last.mode == pcp_pkg::MODE_P2W) || (last.mode == pcp_pkg::MODE_P2C);

   always_comb begin
      res_in = last;
      for (int k = 0; k < 2; k++) begin
         sq[k] = neg_dly_ff[LAT-1][k] ? -(40'(quo[k])) : 40'(quo[k]);
         if (last_proj) begin
            val[k] = pcp_pkg::sat32(sq[k] + $signed({8'b0, c_v[k]}));
         end else begin
            val[k] = pcp_pkg::sat32(sq[k]);
         end
      end
      if (last_proj) begin
         res_in.x = last.bad ? 32'sd0 : val[0];
         res_in.y = last.bad ? 32'sd0 : val[1];
         res_in.z = 32'sd0;
      end else if (last_back) begin
         res_in.x = val[0];
         res_in.y = val[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else if (adv) begin
         res_ff <= res_in;
      end
   end

   assign pt_out = res_ff;

endmodule

>>> hdl/pinhole_camera_projection_core.sv
// ----------------------------------------------------------------------------
// pinhole_camera_projection_core
// Converts one point per request between world, camera and pixel frames.
// ----------------------------------------------------------------------------
// The core accepts one request every clock while the response side does not
// stall, and returns one response per request, in order. A request passes
// through the forward pose rotation, the projection unit (which holds the
// bit-per-stage quotient pipeline of each pixel axis), the inverse rotation
// and the output register. Every stage moves only when the output register
// is empty or being taken, so a stalled response holds the whole pipeline
// without loss.
module pinhole_camera_projection_core #(
   parameter int FRAC_BITS = pcp_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_in_a,
   input  logic signed [31:0] req_in_b,
   input  logic signed [31:0] req_in_c,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic               rsp_depth_invalid,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data
);

   localparam logic [31:0] F_ONE = 32'(1) << FRAC_BITS;

   logic [63:0]          focal_ff, princ_ff;
   pcp_pkg::pcp_row_type row_ff [3];
   pcp_pkg::pcp_vec_type trans_ff;
   pcp_pkg::pcp_mat_type fwd_mat, inv_mat;
   pcp_pkg::pcp_point_type pt_in, pt_rot, pt_prj, pt_inv;

   logic adv;
   logic rsp_valid_ff, rsp_bad_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff  <= {F_ONE, F_ONE};
         princ_ff  <= '0;
         row_ff[0] <= pcp_pkg::ROW0_RST;
         row_ff[1] <= pcp_pkg::ROW1_RST;
         row_ff[2] <= pcp_pkg::ROW2_RST;
         trans_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            pcp_pkg::CSR_FOCAL: focal_ff    <= csr_data;
            pcp_pkg::CSR_PRINC: princ_ff    <= csr_data;
            pcp_pkg::CSR_ROW0:  row_ff[0]   <= csr_data[53:0];
            pcp_pkg::CSR_ROW1:  row_ff[1]   <= csr_data[53:0];
            pcp_pkg::CSR_ROW2:  row_ff[2]   <= csr_data[53:0];
            pcp_pkg::CSR_TX:    trans_ff[0] <= csr_data[31:0];
            pcp_pkg::CSR_TY:    trans_ff[1] <= csr_data[31:0];
            pcp_pkg::CSR_TZ:    trans_ff[2] <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            fwd_mat[i][j] = row_ff[i][18*j +: 18];
            inv_mat[i][j] = row_ff[j][18*i +: 18];
         end
      end
   end

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   assign pt_in.valid = req_valid && adv;
   assign pt_in.mode  = req_mode;
   assign pt_in.bad   = 1'b0;
   assign pt_in.x     = req_in_a;
   assign pt_in.y     = req_in_b;
   assign pt_in.z     = req_in_c;

   pcp_rot u_rot_fwd (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .act_modes ((8'd1 << pcp_pkg::MODE_W2P) | (8'd1 << pcp_pkg::MODE_W2C)),
      .pre_sub   (1'b0),
      .mat       (fwd_mat),
      .trans     (trans_ff),
      .pt_in     (pt_in),
      .pt_out    (pt_rot)
   );

   pcp_proj u_proj (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .fx     (focal_ff[31:0]),
      .fy     (focal_ff[63:32]),
      .cx     (princ_ff[31:0]),
      .cy     (princ_ff[63:32]),
      .pt_in  (pt_rot),
      .pt_out (pt_prj)
   );

   pcp_rot u_rot_inv (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .act_modes ((8'd1 << pcp_pkg::MODE_P2W) | (8'd1 << pcp_pkg::MODE_C2W)),
      .pre_sub   (1'b1),
      .mat       (inv_mat),
      .trans     (trans_ff),
      .pt_in     (pt_prj),
      .pt_out    (pt_inv)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= pt_inv.valid;
         // unused mode codes answer with zeros
         if (pt_inv.mode > pcp_pkg::MODE_C2W) begin
            rsp_x_ff   <= '0;
            rsp_y_ff   <= '0;
            rsp_z_ff   <= '0;
            rsp_bad_ff <= 1'b0;
         end else begin
            rsp_x_ff   <= pt_inv.x;
            rsp_y_ff   <= pt_inv.y;
            rsp_z_ff   <= pt_inv.z;
            rsp_bad_ff <= pt_inv.bad;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_x         = rsp_x_ff;
   assign rsp_out_y         = rsp_y_ff;
   assign rsp_out_z         = rsp_z_ff;
   assign rsp_depth_invalid = rsp_bad_ff;

endmodule

>>> hdl/pcp_checker.sv
// ----------------------------------------------------------------------------
// pcp_checker
// Port-level checks on the pinhole camera projection core, bound to the top.
// ----------------------------------------------------------------------------
`include "pinhole_camera_projection_core_defines.svh"

module pcp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_out_x,
   input logic signed [31:0] rsp_out_y,
   input logic signed [31:0] rsp_out_z,
   input logic               rsp_depth_invalid,
   input logic               csr_ready
);

   // a stalled response holds
   `PCP_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_out_z))

   // bad depth zeroes the point
   `PCP_ASSERT_IMP(a_bad_zero, rsp_valid && rsp_depth_invalid, rsp_out_x == 32'sd0 && rsp_out_y == 32'sd0 && rsp_out_z == 32'sd0)

   // an empty output stage never blocks requests
   `PCP_ASSERT_IMP(a_ready_free, !rsp_valid, req_ready)

   `PCP_ASSERT_IMP(a_rst_empty, $past(reset), !rsp_valid)

   `PCP_ASSERT_IMP(a_csr_ready, 1'b1, csr_ready)

endmodule

bind pinhole_camera_projection_core pcp_checker u_pcp_checker (.*);
